@@ rtl/core/sdu_pkg.sv @@
// Shared constants and types of the screen difference updater.
package sdu_pkg;

   localparam int DEF_MAX_ROWS    = 64;
   localparam int DEF_MAX_COLUMNS = 128;

   // Fixed field widths of the channels.
   localparam int CHAR_W      = 8;
   localparam int OUT_ROW_W   = 6;
   localparam int OUT_COL_W   = 7;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 8;
   localparam int CFG_ROWS_W  = 7;
   localparam int CFG_COLS_W  = 8;

   // Width in which the saturated window sizes are held and compared.
   localparam int SAT_W = 10;

   localparam logic [CSR_INDEX_W-1:0] REG_SCREEN_ROWS    = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SCREEN_COLUMNS = 4'd1;

   localparam logic [CFG_ROWS_W-1:0] ROWS_RESET    = 7'd25;
   localparam logic [CFG_COLS_W-1:0] COLUMNS_RESET = 8'd80;
   localparam int MIN_ROWS    = 3;
   localparam int MIN_COLUMNS = 16;

   localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;

   typedef struct packed {
      logic accept;      // capture the request and read the store
      logic finish;      // compare, update the store and load the result
      logic sweep_step;  // write one blank entry of the clearing pass
   } cmd_type;

   typedef struct packed {
      logic out_busy;    // result register full and not being taken
      logic item_mode;   // captured request is a clear
      logic sweep_last;  // clearing pass is at its final entry
   } status_type;

endpackage

@@ rtl/core/sdu_channels.sv @@
// Channel interfaces of the screen difference updater: request, result and register write.
interface sdu_req_if;
   import sdu_pkg::*;
   logic              valid;
   logic              ready;
   logic              mode;
   logic [CHAR_W-1:0] cell_char;
   modport source (output valid, mode, cell_char, input ready);
   modport sink   (input valid, mode, cell_char, output ready);
   modport mon    (input valid, ready, mode, cell_char);
endinterface

interface sdu_rsp_if;
   import sdu_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 put_valid;
   logic                 move_first;
   logic [OUT_ROW_W-1:0] cell_row;
   logic [OUT_COL_W-1:0] cell_column;
   logic [CHAR_W-1:0]    out_char;
   logic                 frame_done;
   logic                 cleared;
   modport source (output valid, put_valid, move_first, cell_row, cell_column, out_char,
                   frame_done, cleared, input ready);
   modport sink   (input valid, put_valid, move_first, cell_row, cell_column, out_char,
                   frame_done, cleared, output ready);
   modport mon    (input valid, ready, put_valid, move_first, cell_row, cell_column,
                   out_char, frame_done, cleared);
endinterface

interface sdu_csr_if;
   import sdu_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
   modport mon    (input valid, ready, index, data);
endinterface

@@ rtl/core/screen_diff_update.sv @@
// Top level of the screen difference updater.
// The block compares a stream of desired text-screen characters with a store of what the
// terminal shows and emits only the writes needed to bring the terminal up to date.
// The request channel carries one cell per request in row-major order over the text area,
// which is the window less its status line; a request with mode set is a clear instead.
// The result channel carries at most one result per request: a put (with a cursor move
// first when the tracked terminal position is not already at the cell), a refresh request
// on the last cell of a frame, or a clear acknowledgement. An unchanged cell that is not
// the last of a frame yields no result.
// The register channel sets the window rows (index 0) and columns (index 1); it is always
// ready, and a write restarts the scan at the first cell and forgets the tracked position.
// A cell request is handled in steps: it is accepted and the store is read at the scan
// position; then, once the output register is free, the comparison and store update are
// made and the result is loaded into the output register, from which it is offered.
// The single port of the store is why the read and the write of a cell are separate steps.
// A clear request is accepted and acknowledged in the same way; then the store is blanked
// one entry a cycle over all MAX_ROWS * MAX_COLUMNS entries (8192 at the defaults).
// After reset the same clearing pass runs before the first request is accepted.
// When the receiver stalls, the result waits in the output register; the block accepts the
// next request but holds it until the register has been taken.
module screen_diff_update #(
   parameter int MAX_ROWS    = sdu_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLUMNS = sdu_pkg::DEF_MAX_COLUMNS
) (
   input  logic      clock,
   input  logic      reset,
   sdu_req_if.sink   req_chan,
   sdu_rsp_if.source rsp_chan,
   sdu_csr_if.sink   csr_chan
);
   import sdu_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Register writes are taken in every cycle.
   assign csr_chan.ready = 1'b1;

   sdu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   sdu_datapath #(
      .MAX_ROWS    (MAX_ROWS),
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_mode        (req_chan.mode),
      .req_char        (req_chan.cell_char),
      .csr_write       (csr_chan.valid),
      .csr_index       (csr_chan.index),
      .csr_data        (csr_chan.data),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_put_valid   (rsp_chan.put_valid),
      .rsp_move_first  (rsp_chan.move_first),
      .rsp_cell_row    (rsp_chan.cell_row),
      .rsp_cell_column (rsp_chan.cell_column),
      .rsp_out_char    (rsp_chan.out_char),
      .rsp_frame_done  (rsp_chan.frame_done),
      .rsp_cleared     (rsp_chan.cleared)
   );

endmodule

@@ rtl/core/sdu_ctrl.sv @@
// Sequencing state machine of the screen difference updater.
module sdu_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  sdu_pkg::status_type status,
   output sdu_pkg::cmd_type    cmd
);
   import sdu_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_COMP  = 2'd1;
   localparam logic [1:0] ST_SWEEP = 2'd2;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_COMP;
            end
         end
         ST_COMP: begin
            if (!status.out_busy) begin
               cmd.finish = 1'b1;
               state_in   = status.item_mode ? ST_SWEEP : ST_IDLE;
            end
         end
         ST_SWEEP: begin
            cmd.sweep_step = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_SWEEP;
         end
      endcase
   end

   // Reset starts with the clearing pass so the store reads as spaces.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/core/sdu_datapath.sv @@
// Datapath of the screen difference updater: shown store, scan and cursor tracking, result register.
module sdu_datapath #(
   parameter int MAX_ROWS    = sdu_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLUMNS = sdu_pkg::DEF_MAX_COLUMNS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  sdu_pkg::cmd_type                   cmd,
   output sdu_pkg::status_type                status,
   input  logic                               req_mode,
   input  logic [sdu_pkg::CHAR_W-1:0]         req_char,
   input  logic                               csr_write,
   input  logic [sdu_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [sdu_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output logic                               rsp_put_valid,
   output logic                               rsp_move_first,
   output logic [sdu_pkg::OUT_ROW_W-1:0]      rsp_cell_row,
   output logic [sdu_pkg::OUT_COL_W-1:0]      rsp_cell_column,
   output logic [sdu_pkg::CHAR_W-1:0]         rsp_out_char,
   output logic                               rsp_frame_done,
   output logic                               rsp_cleared
);
   import sdu_pkg::*;

   localparam int DEPTH  = MAX_ROWS * MAX_COLUMNS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int COL_W  = $clog2(MAX_COLUMNS);

   logic [CHAR_W-1:0] store_mem [DEPTH];

   logic [CFG_ROWS_W-1:0] rows_cfg_ff, rows_cfg_in;
   logic [CFG_COLS_W-1:0] cols_cfg_ff, cols_cfg_in;
   logic [ROW_W-1:0]      scan_row_ff, scan_row_in;
   logic [COL_W-1:0]      scan_col_ff, scan_col_in;
   logic [ROW_W-1:0]      trk_row_ff, trk_row_in;
   logic [COL_W:0]        trk_col_ff, trk_col_in;
   logic                  known_ff, known_in;
   logic [ADDR_W-1:0]     sweep_cnt_ff, sweep_cnt_in;
   logic                  out_full_ff, out_full_in;
   logic [CHAR_W-1:0]     char_ff;
   logic                  mode_ff;
   logic [CHAR_W-1:0]     rd_ff;

   logic                  put_ff, move_ff, done_ff, clr_ff;
   logic [OUT_ROW_W-1:0]  orow_ff;
   logic [OUT_COL_W-1:0]  ocol_ff;
   logic [CHAR_W-1:0]     ochar_ff;

   logic [SAT_W-1:0]  rows_ext, cols_ext, eff_rows, eff_cols;
   logic [COL_W:0]    next_col;
   logic [ROW_W:0]    next_row;
   logic              col_wrap, frame_end, differs, at_tracked, load_out;
   logic [ADDR_W-1:0] scan_addr, mem_addr;
   logic              mem_we;
   logic [CHAR_W-1:0] mem_wdata;

   // Saturated window size.
   always_comb begin
      rows_ext = SAT_W'(rows_cfg_ff);
      cols_ext = SAT_W'(cols_cfg_ff);
      if (rows_ext < SAT_W'(MIN_ROWS)) begin
         eff_rows = SAT_W'(MIN_ROWS);
      end else if (rows_ext > SAT_W'(MAX_ROWS)) begin
         eff_rows = SAT_W'(MAX_ROWS);
      end else begin
         eff_rows = rows_ext;
      end
      if (cols_ext < SAT_W'(MIN_COLUMNS)) begin
         eff_cols = SAT_W'(MIN_COLUMNS);
      end else if (cols_ext > SAT_W'(MAX_COLUMNS)) begin
         eff_cols = SAT_W'(MAX_COLUMNS);
      end else begin
         eff_cols = cols_ext;
      end
   end

   assign scan_addr = ADDR_W'(ADDR_W'(scan_row_ff) * ADDR_W'(MAX_COLUMNS))
                      + ADDR_W'(scan_col_ff);
   assign next_col  = {1'b0, scan_col_ff} + 1'b1;
   assign next_row  = {1'b0, scan_row_ff} + 1'b1;
   assign col_wrap  = SAT_W'(next_col) >= eff_cols;
   assign frame_end = col_wrap && (SAT_W'(next_row) >= eff_rows - SAT_W'(1));
   assign differs   = rd_ff != char_ff;
   assign at_tracked = known_ff && (trk_row_ff == scan_row_ff)
                       && (trk_col_ff == {1'b0, scan_col_ff});
   assign load_out  = cmd.finish && (mode_ff || differs || frame_end);

   assign mem_we    = cmd.sweep_step || (cmd.finish && !mode_ff && differs);
   assign mem_addr  = cmd.sweep_step ? sweep_cnt_ff : scan_addr;
   assign mem_wdata = cmd.sweep_step ? SPACE_CHAR : char_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_addr] <= mem_wdata;
      end
      if (cmd.accept) begin
         rd_ff <= store_mem[mem_addr];
      end
   end

   always_comb begin
      rows_cfg_in  = rows_cfg_ff;
      cols_cfg_in  = cols_cfg_ff;
      scan_row_in  = scan_row_ff;
      scan_col_in  = scan_col_ff;
      trk_row_in   = trk_row_ff;
      trk_col_in   = trk_col_ff;
      known_in     = known_ff;
      sweep_cnt_in = sweep_cnt_ff;
      out_full_in  = out_full_ff && !rsp_ready;

      if (cmd.sweep_step) begin
         sweep_cnt_in = status.sweep_last ? '0 : sweep_cnt_ff + 1'b1;
      end

      if (cmd.finish) begin
         if (mode_ff) begin
            scan_row_in = '0;
            scan_col_in = '0;
            trk_row_in  = '0;
            trk_col_in  = '0;
            known_in    = 1'b0;
         end else begin
            if (differs) begin
               trk_row_in = scan_row_ff;
               trk_col_in = next_col;
               known_in   = 1'b1;
            end
            if (col_wrap) begin
               scan_col_in = '0;
               if (frame_end) begin
                  scan_row_in = '0;
                  trk_row_in  = '0;
                  trk_col_in  = '0;
                  known_in    = 1'b0;
               end else begin
                  scan_row_in = next_row[ROW_W-1:0];
               end
            end else begin
               scan_col_in = next_col[COL_W-1:0];
            end
         end
      end

      if (load_out) begin
         out_full_in = 1'b1;
      end

      // A register write restarts the scan; the store keeps its contents.
      if (csr_write && (csr_index == REG_SCREEN_ROWS || csr_index == REG_SCREEN_COLUMNS)) begin
         if (csr_index == REG_SCREEN_ROWS) begin
            rows_cfg_in = csr_data[CFG_ROWS_W-1:0];
         end else begin
            cols_cfg_in = csr_data[CFG_COLS_W-1:0];
         end
         scan_row_in = '0;
         scan_col_in = '0;
         trk_row_in  = '0;
         trk_col_in  = '0;
         known_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_cfg_ff  <= ROWS_RESET;
         cols_cfg_ff  <= COLUMNS_RESET;
         scan_row_ff  <= '0;
         scan_col_ff  <= '0;
         trk_row_ff   <= '0;
         trk_col_ff   <= '0;
         known_ff     <= 1'b0;
         sweep_cnt_ff <= '0;
         out_full_ff  <= 1'b0;
      end else begin
         rows_cfg_ff  <= rows_cfg_in;
         cols_cfg_ff  <= cols_cfg_in;
         scan_row_ff  <= scan_row_in;
         scan_col_ff  <= scan_col_in;
         trk_row_ff   <= trk_row_in;
         trk_col_ff   <= trk_col_in;
         known_ff     <= known_in;
         sweep_cnt_ff <= sweep_cnt_in;
         out_full_ff  <= out_full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         char_ff <= req_char;
         mode_ff <= req_mode;
      end
      if (load_out) begin
         clr_ff <= mode_ff;
         if (mode_ff) begin
            put_ff   <= 1'b0;
            move_ff  <= 1'b0;
            done_ff  <= 1'b0;
            orow_ff  <= '0;
            ocol_ff  <= '0;
            ochar_ff <= '0;
         end else begin
            put_ff   <= differs;
            move_ff  <= differs && !at_tracked;
            done_ff  <= frame_end;
            orow_ff  <= differs ? OUT_ROW_W'(scan_row_ff) : '0;
            ocol_ff  <= differs ? OUT_COL_W'(scan_col_ff) : '0;
            ochar_ff <= differs ? char_ff : '0;
         end
      end
   end

   assign status.out_busy   = out_full_ff && !rsp_ready;
   assign status.item_mode  = mode_ff;
   assign status.sweep_last = sweep_cnt_ff == ADDR_W'(DEPTH - 1);

   assign rsp_valid       = out_full_ff;
   assign rsp_put_valid   = put_ff;
   assign rsp_move_first  = move_ff;
   assign rsp_cell_row    = orow_ff;
   assign rsp_cell_column = ocol_ff;
   assign rsp_out_char    = ochar_ff;
   assign rsp_frame_done  = done_ff;
   assign rsp_cleared     = clr_ff;

endmodule

@@ rtl/core/sdu_check.sv @@
// Port-level assertions for the screen difference updater and their binding.
module sdu_check (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          req_mode,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_put_valid,
   input logic                          rsp_move_first,
   input logic [sdu_pkg::OUT_ROW_W-1:0] rsp_cell_row,
   input logic [sdu_pkg::OUT_COL_W-1:0] rsp_cell_column,
   input logic [sdu_pkg::CHAR_W-1:0]    rsp_out_char,
   input logic                          rsp_frame_done,
   input logic                          rsp_cleared
);

   // A stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn while stalled");

   // A clear acknowledgement carries no put, no refresh request and no character.
   a_clear_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cleared |->
         !rsp_put_valid && !rsp_frame_done && rsp_out_char == '0)
      else $error("clear result carries other fields");

   // A result without a put has no cursor move and no cell payload.
   a_no_put_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_put_valid |->
         !rsp_move_first && rsp_cell_row == '0 &&
         rsp_cell_column == '0 && rsp_out_char == '0)
      else $error("result without put carries payload");

   // A clear request is followed by the blanking pass, which takes no request.
   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode |=> ##1 !req_ready)
      else $error("request taken during clearing pass");

   // The store is blanked after reset before any request is taken.
   a_reset_busy: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request ready straight after reset");

endmodule

bind screen_diff_update sdu_check u_sdu_check (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .req_mode        (req_chan.mode),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_put_valid   (rsp_chan.put_valid),
   .rsp_move_first  (rsp_chan.move_first),
   .rsp_cell_row    (rsp_chan.cell_row),
   .rsp_cell_column (rsp_chan.cell_column),
   .rsp_out_char    (rsp_chan.out_char),
   .rsp_frame_done  (rsp_chan.frame_done),
   .rsp_cleared     (rsp_chan.cleared)
);
